[rtl/core/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the DAC setpoint autorange block.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int unsigned CODE_BITS = 16;
   localparam int unsigned VAL_W     = 23;
   localparam int unsigned FRAME_W   = 16;
   localparam int unsigned REG_W     = 4;

   // full scale in half-microvolt units: reference shifted left by up to two
   localparam int unsigned FS_W   = VAL_W + 2;
   localparam int unsigned DEN_W  = FS_W + 1;
   localparam int unsigned QUO_W  = CODE_BITS + 1;
   localparam int unsigned DIV_W  = DEN_W + QUO_W;
   localparam int unsigned CNT_W  = $clog2(QUO_W);

   localparam int unsigned ALIGN_UP   = (CODE_BITS <= FRAME_W) ? FRAME_W - CODE_BITS : 0;
   localparam int unsigned ALIGN_DOWN = (CODE_BITS > FRAME_W) ? CODE_BITS - FRAME_W : 0;
   localparam int unsigned ALIGN_W    = FRAME_W + CODE_BITS;

   localparam logic [REG_W-1:0] REG_NONE = 4'd0;
   localparam logic [REG_W-1:0] REG_GAIN = 4'd4;
   localparam logic [REG_W-1:0] REG_DAC  = 4'd8;

   localparam logic CSR_REFERENCE  = 1'b0;
   localparam logic CSR_MAX_OUTPUT = 1'b1;

   localparam logic [VAL_W-1:0] REFERENCE_RESET  = 23'd2500000;
   localparam logic [VAL_W-1:0] MAX_OUTPUT_RESET = 23'd5500000;

   typedef enum logic [1:0] {
      TIER_HALF   = 2'd0,
      TIER_REF    = 2'd1,
      TIER_DOUBLE = 2'd2
   } tier_type;

   typedef enum logic [1:0] {
      SEL_ERR,
      SEL_GAIN,
      SEL_DAC
   } out_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ERR,
      ST_GAIN,
      ST_DIV,
      ST_DAC
   } state_type;

   typedef struct packed {
      logic        load;
      logic        check;
      logic        commit_gain;
      logic        div_step;
      out_sel_type out_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic range_err;
      logic need_gain;
      logic div_last;
   } dp_status_type;

endpackage

[rtl/core/dsa_ctrl.sv]
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: accept, range check, error or gain frame, divide, DAC frame.
// ----------------------------------------------------------------------------
module dsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_last,
   input  dsa_pkg::dp_status_type status,
   output dsa_pkg::ctrl_cmd_type  cmd
);
   import dsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      rsp_last        = 1'b0;
      cmd.load        = 1'b0;
      cmd.check       = 1'b0;
      cmd.commit_gain = 1'b0;
      cmd.div_step    = 1'b0;
      cmd.out_sel     = SEL_DAC;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.range_err) begin
               state_in = ST_ERR;
            end else if (status.need_gain) begin
               state_in = ST_GAIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_ERR: begin
            rsp_valid   = 1'b1;
            rsp_last    = 1'b1;
            cmd.out_sel = SEL_ERR;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_GAIN: begin
            rsp_valid   = 1'b1;
            cmd.out_sel = SEL_GAIN;
            if (rsp_ready) begin
               cmd.commit_gain = 1'b1;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DAC;
            end
         end
         ST_DAC: begin
            rsp_valid   = 1'b1;
            rsp_last    = 1'b1;
            cmd.out_sel = SEL_DAC;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/dsa_datapath.sv]
// ----------------------------------------------------------------------------
// dsa_datapath
// Config and gain state, tier select, restoring divider, frame formatting.
// ----------------------------------------------------------------------------
module dsa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [dsa_pkg::VAL_W-1:0]           csr_data,
   input  logic [dsa_pkg::VAL_W-1:0]           req_target_uv,
   input  dsa_pkg::ctrl_cmd_type               cmd,
   output dsa_pkg::dp_status_type              status,
   output logic [dsa_pkg::REG_W-1:0]           rsp_frame_reg,
   output logic [dsa_pkg::FRAME_W-1:0]         rsp_frame_data,
   output logic                                rsp_range_error
);
   import dsa_pkg::*;

   logic [VAL_W-1:0] reference_ff;
   logic [VAL_W-1:0] max_output_ff;
   logic             gain_ff;
   logic             halved_ff;
   logic [VAL_W-1:0] target_ff;
   tier_type         tier_ff;
   logic             special_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;

   tier_type             tier_cur;
   tier_type             tier_tgt;
   logic [FS_W-1:0]      fs_cur;
   logic [FS_W-1:0]      fs_tgt;
   logic [VAL_W:0]       target2;
   logic                 fits;
   logic [CODE_BITS-1:0] code;
   logic [ALIGN_W-1:0]   code_aligned;
   logic [FRAME_W-1:0]   gain_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff  <= REFERENCE_RESET;
         max_output_ff <= MAX_OUTPUT_RESET;
         gain_ff       <= 1'b1;
         halved_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_REFERENCE:  reference_ff  <= csr_data;
               CSR_MAX_OUTPUT: max_output_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.commit_gain) begin
            gain_ff   <= (tier_ff == TIER_DOUBLE);
            halved_ff <= (tier_ff == TIER_HALF);
         end
      end
   end

   assign target2 = {target_ff, 1'b0};

   always_comb begin
      unique case ({halved_ff, gain_ff})
         2'b10:   tier_cur = TIER_HALF;
         2'b01:   tier_cur = TIER_DOUBLE;
         default: tier_cur = TIER_REF;
      endcase
      if (target_ff > reference_ff) begin
         tier_tgt = TIER_DOUBLE;
      end else if (target2 > {1'b0, reference_ff}) begin
         tier_tgt = TIER_REF;
      end else begin
         tier_tgt = TIER_HALF;
      end
   end

   assign fs_cur = FS_W'(reference_ff) << tier_cur;
   assign fs_tgt = FS_W'(reference_ff) << tier_tgt;

   assign status.range_err = (target_ff > max_output_ff) ||
                             ({1'b0, target_ff} > {reference_ff, 1'b0});
   assign status.need_gain = (fs_cur != fs_tgt);
   assign status.div_last  = (cnt_ff == '0);

   // restoring divide: round(v * 2^(CODE_BITS+1) / fs), ties up
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= req_target_uv;
      end
      if (cmd.check) begin
         tier_ff    <= tier_tgt;
         special_ff <= (FS_W'(target2) == fs_tgt) || (fs_tgt == '0);
         rem_ff     <= (DIV_W'(target_ff) << (CODE_BITS + 2)) + DIV_W'(fs_tgt);
         dsh_ff     <= DIV_W'({fs_tgt, 1'b0}) << CODE_BITS;
         quo_ff     <= '0;
         cnt_ff     <= CNT_W'(QUO_W - 1);
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign fits = !quo_ff[QUO_W-1];
   assign code = (special_ff || !fits) ? '1 : quo_ff[CODE_BITS-1:0];
   assign code_aligned = (ALIGN_W'(code) << ALIGN_UP) >> ALIGN_DOWN;

   always_comb begin
      gain_data    = '0;
      gain_data[0] = (tier_ff == TIER_DOUBLE);
      gain_data[8] = (tier_ff == TIER_HALF);
   end

   always_comb begin
      unique case (cmd.out_sel)
         SEL_ERR: begin
            rsp_frame_reg   = REG_NONE;
            rsp_frame_data  = '0;
            rsp_range_error = 1'b1;
         end
         SEL_GAIN: begin
            rsp_frame_reg   = REG_GAIN;
            rsp_frame_data  = gain_data;
            rsp_range_error = 1'b0;
         end
         default: begin
            rsp_frame_reg   = REG_DAC;
            rsp_frame_data  = code_aligned[FRAME_W-1:0];
            rsp_range_error = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/dac_setpoint_autorange.sv]
// ----------------------------------------------------------------------------
// dac_setpoint_autorange
// Sequence: accept, ST_CHECK, an optional gain frame in ST_GAIN, the divide in
//   ST_DIV, then the DAC frame in ST_DAC; errors go from ST_CHECK to ST_ERR.
// Flow: one transaction at a time, req_ready high only in ST_IDLE; the
//   17-step restoring divider produces one quotient bit per cycle.
// Reset: synchronous; reference 2.5 V, max output 5.5 V, gain of two, no
//   division. No clearing pass.
// ----------------------------------------------------------------------------
module dac_setpoint_autorange (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [dsa_pkg::VAL_W-1:0]         csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dsa_pkg::VAL_W-1:0]         req_target_uv,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dsa_pkg::REG_W-1:0]         rsp_frame_reg,
   output logic [dsa_pkg::FRAME_W-1:0]       rsp_frame_data,
   output logic                              rsp_range_error,
   output logic                              rsp_last
);
   import dsa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   dsa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_target_uv   (req_target_uv),
      .cmd             (cmd),
      .status          (status),
      .rsp_frame_reg   (rsp_frame_reg),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_range_error (rsp_range_error)
   );

endmodule
